// ===== rtl/hse_pkg.sv =====
// Shared constants and the signed compare used by the heap sort engine.
`default_nettype none
package hse_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;

  typedef logic signed [DATA_W-1:0] data_t;

  // Signed greater-than on two's complement words
  function automatic logic hse_gt(input data_t a, input data_t b);
    return a > b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hse_ram #(
  parameter int WIDTH = hse_pkg::DATA_W,
  parameter int DEPTH = hse_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same address is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/heap_sort_engine_unit.sv =====
// Heap sort engine: loads a data set, heapsorts it in RAM and streams it out ascending.
// Loading: one value per cycle; in_stall is high from the closing transfer to the final result.
// Sift-down reads the node and its children, moves the larger child up while it beats the
//   node and descends; root/end swap exchanges the two ends. Speed is set by the single RAM
//   read port and the shared comparator. Output: each result is held until taken.
// Reset (rst, synchronous) empties the set and drops out_valid; RAM contents are not cleared.
`default_nettype none
module heap_sort_engine_unit #(
  parameter int DEPTH = hse_pkg::DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire hse_pkg::data_t        value,
  input  wire logic                  last,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output hse_pkg::data_t             sorted_value,
  output logic                       final_res,
  output logic                       out_valid,
  input  wire logic                  out_stall
);
  import hse_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SD_START,
    S_SD_LOADN,
    S_SD_CMPL,
    S_SD_CMPR,
    S_SD_SWAP,
    S_SD_SWAP2,
    S_SD_DONE,
    S_SW_RD0,
    S_SW_RDE,
    S_SW_WR0,
    S_SW_WRE,
    S_EM_RD,
    S_EM_WAIT,
    S_EM_HOLD
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] total;
  logic [CW-1:0] size;
  logic [CW-1:0] hend;
  logic [AW-1:0] bi;
  logic [AW-1:0] node;
  logic [AW-1:0] best;
  logic [AW-1:0] k;
  logic          build;
  data_t         node_val;
  data_t         best_val;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  data_t         ram_wdata;
  logic [AW-1:0] ram_raddr;
  data_t         ram_rdata;

  logic [IW-1:0] lchild;
  logic [IW-1:0] rchild;
  logic [IW-1:0] bchild;
  logic [IW-1:0] size_x;
  logic [CW-1:0] n_close;
  logic          cmp_gt;
  logic          closing;

  hse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Child indexes and the shared comparator
  assign lchild  = (IW'(node) << 1) + IW'(1);
  assign rchild  = (IW'(node) << 1) + IW'(2);
  assign bchild  = (IW'(best) << 1) + IW'(1);
  assign size_x  = IW'(size);
  assign cmp_gt  = hse_gt(ram_rdata, best_val);
  assign n_close = count + CW'(1);
  assign closing = last || (count == CW'(DEPTH - 1));

  assign in_stall = (state != S_IDLE);

  // RAM port steering per sequencer step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node;
    ram_wdata = node_val;
    ram_raddr = node;
    case (state)
      S_IDLE: begin
        ram_we    = in_valid;
        ram_waddr = count[AW-1:0];
        ram_wdata = value;
      end
      S_SD_START: ram_raddr = node;
      S_SD_LOADN: ram_raddr = lchild[AW-1:0];
      S_SD_CMPL:  ram_raddr = rchild[AW-1:0];
      S_SD_SWAP: begin
        ram_we    = (best != node);
        ram_waddr = node;
        ram_wdata = best_val;
      end
      S_SD_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = best;
        ram_wdata = node_val;
        ram_raddr = bchild[AW-1:0];
      end
      S_SW_RD0: ram_raddr = '0;
      S_SW_RDE: ram_raddr = AW'(hend - CW'(1));
      S_SW_WR0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
      end
      S_SW_WRE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(hend - CW'(1));
        ram_wdata = node_val;
      end
      S_EM_RD: ram_raddr = k;
      default: ram_raddr = node;
    endcase
  end

  // Sequencer: load, heap build, sort-down, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (closing) begin
              count <= '0;
              total <= n_close;
              size  <= n_close;
              bi    <= AW'(n_close >> 1);
              node  <= AW'(n_close >> 1);
              build <= 1'b1;
              state <= S_SD_START;
            end else begin
              count <= n_close;
            end
          end
        end
        S_SD_START: state <= S_SD_LOADN;
        S_SD_LOADN: begin
          node_val <= ram_rdata;
          best_val <= ram_rdata;
          best     <= node;
          state    <= (lchild < size_x) ? S_SD_CMPL : S_SD_DONE;
        end
        S_SD_CMPL: begin
          if (cmp_gt) begin
            best     <= lchild[AW-1:0];
            best_val <= ram_rdata;
          end
          state <= (rchild < size_x) ? S_SD_CMPR : S_SD_SWAP;
        end
        S_SD_CMPR: begin
          if (cmp_gt) begin
            best     <= rchild[AW-1:0];
            best_val <= ram_rdata;
          end
          state <= S_SD_SWAP;
        end
        S_SD_SWAP: state <= (best == node) ? S_SD_DONE : S_SD_SWAP2;
        S_SD_SWAP2: begin
          // moved value keeps sinking; it is the new reference for compares
          node     <= best;
          best_val <= node_val;
          state    <= (bchild < size_x) ? S_SD_CMPL : S_SD_DONE;
        end
        S_SD_DONE: begin
          if (build) begin
            if (bi == '0) begin
              if (total > CW'(1)) begin
                hend  <= total;
                state <= S_SW_RD0;
              end else begin
                k     <= '0;
                state <= S_EM_RD;
              end
            end else begin
              bi    <= bi - AW'(1);
              node  <= bi - AW'(1);
              size  <= total;
              state <= S_SD_START;
            end
          end else if (hend > CW'(2)) begin
            hend  <= hend - CW'(1);
            state <= S_SW_RD0;
          end else begin
            k     <= '0;
            state <= S_EM_RD;
          end
        end
        S_SW_RD0: state <= S_SW_RDE;
        S_SW_RDE: begin
          node_val <= ram_rdata;
          state    <= S_SW_WR0;
        end
        S_SW_WR0: state <= S_SW_WRE;
        S_SW_WRE: begin
          build <= 1'b0;
          node  <= '0;
          size  <= hend - CW'(1);
          state <= S_SD_START;
        end
        S_EM_RD: state <= S_EM_WAIT;
        S_EM_WAIT: begin
          sorted_value <= ram_rdata;
          final_res    <= (CW'(k) == total - CW'(1));
          out_valid    <= 1'b1;
          state        <= S_EM_HOLD;
        end
        S_EM_HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (final_res) begin
              state <= S_IDLE;
            end else begin
              k     <= k + AW'(1);
              state <= S_EM_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // No input transfer while results are pending
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input taken while a result is pending");

  // Fill count stays inside the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count < CW'(DEPTH))
    else $error("item count out of range");

  // Taking the final result ends the set
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_res && !out_stall |=> !out_valid && !in_stall)
    else $error("block not idle after final result");

  // Writes never go past the store
  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ram_waddr < AW'(DEPTH - 1)) || (ram_waddr == AW'(DEPTH - 1)))
    else $error("store write out of range");
`endif

endmodule
`default_nettype wire
